// ===== design/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue: action and status
// codes, controller states and data widths.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DATA_W           = 32;
  localparam int OCC_W            = 5;
  localparam int DEFAULT_CAPACITY = 16;

  // value reported for a missing element or a failed pop
  localparam logic signed [DATA_W-1:0] EMPTY_MARK = -32'sd1;

  typedef enum logic [1:0] {
    ACT_PUSH_FRONT = 2'd0,
    ACT_PUSH_REAR  = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_REAR   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_FETCH
  } state_t;

endpackage

// ===== design/deq_if.sv =====
// ----------------------------------------------------------------------------
// deq_if
// Valid/ready channels of the double-ended queue: requests in, results out.
// ----------------------------------------------------------------------------
interface deq_req_if import deq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  action_t                  action;
  logic signed [DATA_W-1:0] push_value;

  modport source (output valid, action, push_value, input ready);
  modport sink   (input valid, action, push_value, output ready);
endinterface

interface deq_rsp_if import deq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] popped_value;
  status_t                  status;
  logic                     is_empty;
  logic                     is_full;
  logic [OCC_W-1:0]         occupancy;
  logic signed [DATA_W-1:0] front_value;
  logic signed [DATA_W-1:0] rear_value;

  modport source (output valid, popped_value, status, is_empty, is_full, occupancy,
                  front_value, rear_value, input ready);
  modport sink   (input valid, popped_value, status, is_empty, is_full, occupancy,
                  front_value, rear_value, output ready);
endinterface

// ===== design/deq_ram.sv =====
// ----------------------------------------------------------------------------
// deq_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module deq_ram import deq_pkg::*; #(
  parameter int WIDTH = DATA_W,
  parameter int DEPTH = DEFAULT_CAPACITY,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/double_ended_queue.sv =====
// A push, a pop that leaves the deque empty, and a pop on an empty deque
// give their result in the cycle after the transaction; any other pop goes
// through S_FETCH first, the slot store read of the new front or rear.
// Throughput: one transaction per cycle while the result side is ready; a pop
// that refills a cached end holds off the next transaction during S_FETCH.
// Reset (synchronous, rst high) empties the deque; the slot store is not cleared.
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed 32-bit values in a ring buffer RAM. Front and rear
// values are cached in registers, so a pop reads the RAM only to refill them.
// ----------------------------------------------------------------------------
module double_ended_queue import deq_pkg::*; #(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic     clk,
  input  logic     rst,
  deq_req_if.sink  req,
  deq_rsp_if.source rsp
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  // ring index helpers
  function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] idx);
    return (idx == IW'(CAPACITY - 1)) ? '0 : idx + 1'b1;
  endfunction

  function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] idx);
    return (idx == '0) ? IW'(CAPACITY - 1) : idx - 1'b1;
  endfunction

  state_t state, state_next;

  logic [IW-1:0] head, head_next;
  logic [IW-1:0] rear_idx, rear_idx_next;
  logic [CW-1:0] count, count_next;
  logic signed [DATA_W-1:0] front_val, front_val_next;
  logic signed [DATA_W-1:0] rear_val, rear_val_next;
  logic fetch_front, fetch_front_next;

  logic                     out_valid;
  logic signed [DATA_W-1:0] out_popped;
  status_t                  out_status;
  logic                     out_empty;
  logic                     out_full;
  logic [OCC_W-1:0]         out_occ;
  logic signed [DATA_W-1:0] out_front;
  logic signed [DATA_W-1:0] out_rear;

  logic                     accept;
  logic                     is_empty_now;
  logic                     is_full_now;
  logic                     need_fetch;
  logic                     load_out;
  logic signed [DATA_W-1:0] res_popped;
  status_t                  res_status;

  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  logic              rd_en;
  logic [IW-1:0]     rd_addr;
  logic [DATA_W-1:0] rd_data;

  assign accept       = req.valid && req.ready;
  assign is_empty_now = (count == '0);
  assign is_full_now  = (count == CW'(CAPACITY));

  // slot store
  deq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_slots (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (req.push_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && need_fetch) begin
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // controller outputs
  always_comb begin
    req.ready = 1'b0;
    load_out  = 1'b0;
    case (state)
      S_IDLE: begin
        req.ready = !out_valid || rsp.ready;
        load_out  = accept && !need_fetch;
      end
      S_FETCH: begin
        load_out = 1'b1;
      end
      default: begin
        req.ready = 1'b0;
        load_out  = 1'b0;
      end
    endcase
  end

  // pointer, count and cache updates
  always_comb begin
    head_next        = head;
    rear_idx_next    = rear_idx;
    count_next       = count;
    front_val_next   = front_val;
    rear_val_next    = rear_val;
    fetch_front_next = fetch_front;
    wr_en            = 1'b0;
    wr_addr          = head;
    rd_en            = 1'b0;
    rd_addr          = head;
    need_fetch       = 1'b0;
    res_popped       = '0;
    res_status       = ST_DONE;

    if (state == S_FETCH) begin
      // refill the cached end from the slot read
      if (fetch_front) begin
        front_val_next = rd_data;
      end else begin
        rear_val_next = rd_data;
      end
    end else if (accept) begin
      case (req.action)
        ACT_PUSH_FRONT: begin
          if (is_full_now) begin
            res_status = ST_OVERFLOW;
          end else begin
            head_next      = idx_dec(head);
            wr_en          = 1'b1;
            wr_addr        = idx_dec(head);
            count_next     = count + 1'b1;
            front_val_next = req.push_value;
            if (is_empty_now) begin
              rear_val_next = req.push_value;
            end
          end
        end
        ACT_PUSH_REAR: begin
          if (is_full_now) begin
            res_status = ST_OVERFLOW;
          end else begin
            rear_idx_next = idx_inc(rear_idx);
            wr_en         = 1'b1;
            wr_addr       = idx_inc(rear_idx);
            count_next    = count + 1'b1;
            rear_val_next = req.push_value;
            if (is_empty_now) begin
              front_val_next = req.push_value;
            end
          end
        end
        ACT_POP_FRONT: begin
          if (is_empty_now) begin
            res_popped = EMPTY_MARK;
            res_status = ST_UNDERFLOW;
          end else begin
            res_popped = front_val;
            head_next  = idx_inc(head);
            count_next = count - 1'b1;
            if (count != CW'(1)) begin
              rd_en            = 1'b1;
              rd_addr          = idx_inc(head);
              need_fetch       = 1'b1;
              fetch_front_next = 1'b1;
            end
          end
        end
        ACT_POP_REAR: begin
          if (is_empty_now) begin
            res_popped = EMPTY_MARK;
            res_status = ST_UNDERFLOW;
          end else begin
            res_popped    = rear_val;
            rear_idx_next = idx_dec(rear_idx);
            count_next    = count - 1'b1;
            if (count != CW'(1)) begin
              rd_en            = 1'b1;
              rd_addr          = idx_dec(rear_idx);
              need_fetch       = 1'b1;
              fetch_front_next = 1'b0;
            end
          end
        end
        default: begin
          res_status = ST_DONE;
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      rear_idx  <= IW'(CAPACITY - 1);
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      head     <= head_next;
      rear_idx <= rear_idx_next;
      count    <= count_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // cached ends and result payload
  always_ff @(posedge clk) begin
    front_val   <= front_val_next;
    rear_val    <= rear_val_next;
    fetch_front <= fetch_front_next;
    if (accept) begin
      out_popped <= res_popped;
      out_status <= res_status;
    end
    if (load_out) begin
      out_empty <= (count_next == '0);
      out_full  <= (count_next == CW'(CAPACITY));
      out_occ   <= OCC_W'(count_next);
      out_front <= (count_next == '0) ? EMPTY_MARK : front_val_next;
      out_rear  <= (count_next == '0) ? EMPTY_MARK : rear_val_next;
    end
  end

  // result channel
  assign rsp.valid        = out_valid;
  assign rsp.popped_value = out_popped;
  assign rsp.status       = out_status;
  assign rsp.is_empty     = out_empty;
  assign rsp.is_full      = out_full;
  assign rsp.occupancy    = out_occ;
  assign rsp.front_value  = out_front;
  assign rsp.rear_value   = out_rear;

`ifndef SYNTHESIS
  // count never passes the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("deque count above capacity");

  // no new transaction while a slot read is outstanding
  a_fetch_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH) |-> !req.ready)
    else $error("request accepted during fetch");

  // the result register is free when fetched data arrives
  a_fetch_out_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH) |-> !out_valid)
    else $error("result register busy during fetch");

  // a push into a non-full deque adds one element
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && !req.action[1] && !is_full_now) |=> (count == $past(count) + 1'b1))
    else $error("push did not grow the deque");
`endif

endmodule

// ===== tb/double_ended_queue_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// double_ended_queue_test
// Self-checking bench for the double-ended queue. A short table of directed
// requests covers empty pops, extreme values, a -1 payload, filling to
// capacity and pushes into a full deque. Then about 800 random requests follow,
// in bursts that favour pushes, pops or neither so the occupancy swings between
// empty and full. Every response is checked field by field against an
// in-bench copy of the deque. Both channels idle at random.
// ----------------------------------------------------------------------------
module double_ended_queue_test;
  import deq_pkg::*;

  localparam int CAP          = DEFAULT_CAPACITY;
  localparam int RANDOM_ITEMS = 800;
  localparam int BURST_LEN    = 40;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 4;

  typedef struct {
    logic signed [DATA_W-1:0] popped_value;
    status_t                  status;
    logic                     is_empty;
    logic                     is_full;
    logic [OCC_W-1:0]         occupancy;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] rear_value;
  } deq_response_t;

  typedef struct {
    action_t                  act;
    logic signed [DATA_W-1:0] value;
    bit                       typed;
    deq_response_t            resp;
  } stim_row_t;

  localparam logic signed [DATA_W-1:0] MAX_VAL = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] MIN_VAL = 32'sh8000_0000;
  localparam deq_response_t NO_RESP =
    '{32'sd0, ST_DONE, 1'b0, 1'b0, 5'd0, 32'sd0, 32'sd0};
  localparam deq_response_t EMPTY_POP_RESP =
    '{EMPTY_MARK, ST_UNDERFLOW, 1'b1, 1'b0, 5'd0, EMPTY_MARK, EMPTY_MARK};

  logic clk;
  logic rst;

  deq_req_if req ();
  deq_rsp_if rsp ();

  double_ended_queue #(.CAPACITY(CAP)) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // bench copy of the deque
  logic signed [DATA_W-1:0] slot_copy [CAP];
  int                       front_slot;
  int                       held;

  deq_response_t awaited_responses [$];
  int            fault_count;
  int            req_gap_max;
  int            rsp_stall_max;
  int            stall_left;
  int            quiet_cycles;

  stim_row_t directed_rows [27] = '{
    '{ACT_POP_FRONT,  32'sd0,         1'b1, EMPTY_POP_RESP},
    '{ACT_POP_REAR,   MAX_VAL,        1'b1, EMPTY_POP_RESP},
    '{ACT_PUSH_FRONT, MAX_VAL,        1'b1,
      '{32'sd0, ST_DONE, 1'b0, 1'b0, 5'd1, MAX_VAL, MAX_VAL}},
    '{ACT_PUSH_REAR,  MIN_VAL,        1'b1,
      '{32'sd0, ST_DONE, 1'b0, 1'b0, 5'd2, MAX_VAL, MIN_VAL}},
    '{ACT_POP_FRONT,  32'sd0,         1'b0, NO_RESP},
    '{ACT_POP_REAR,   32'sd0,         1'b0, NO_RESP},
    '{ACT_PUSH_REAR,  -32'sd1,        1'b1,
      '{32'sd0, ST_DONE, 1'b0, 1'b0, 5'd1, -32'sd1, -32'sd1}},
    '{ACT_POP_FRONT,  32'sd0,         1'b1,
      '{-32'sd1, ST_DONE, 1'b1, 1'b0, 5'd0, EMPTY_MARK, EMPTY_MARK}},
    '{ACT_PUSH_FRONT, 32'sh0000_0001, 1'b0, NO_RESP},
    '{ACT_PUSH_REAR,  32'shffff_fffe, 1'b0, NO_RESP},
    '{ACT_PUSH_FRONT, 32'sh5555_5555, 1'b0, NO_RESP},
    '{ACT_PUSH_REAR,  32'shaaaa_aaaa, 1'b0, NO_RESP},
    '{ACT_PUSH_FRONT, 32'sh0000_ffff, 1'b0, NO_RESP},
    '{ACT_PUSH_REAR,  32'shffff_0000, 1'b0, NO_RESP},
    '{ACT_PUSH_FRONT, 32'sh0f0f_0f0f, 1'b0, NO_RESP},
    '{ACT_PUSH_REAR,  32'shf0f0_f0f0, 1'b0, NO_RESP},
    '{ACT_PUSH_FRONT, MIN_VAL,        1'b0, NO_RESP},
    '{ACT_PUSH_REAR,  MAX_VAL,        1'b0, NO_RESP},
    '{ACT_PUSH_FRONT, 32'sh3333_3333, 1'b0, NO_RESP},
    '{ACT_PUSH_REAR,  32'shcccc_cccc, 1'b0, NO_RESP},
    '{ACT_PUSH_FRONT, 32'sd0,         1'b0, NO_RESP},
    '{ACT_PUSH_REAR,  -32'sd1,        1'b0, NO_RESP},
    '{ACT_PUSH_FRONT, 32'sh1234_5678, 1'b0, NO_RESP},
    '{ACT_PUSH_REAR,  32'sh8765_4321, 1'b0, NO_RESP},
    '{ACT_PUSH_FRONT, 32'sh0bad_cafe, 1'b0, NO_RESP},
    '{ACT_PUSH_REAR,  32'sh7777_7777, 1'b0, NO_RESP},
    '{ACT_PUSH_FRONT, 32'sh1111_1111, 1'b0, NO_RESP}
  };

  // clock
  always #4 clk = ~clk;

  // next response of the deque for one request, updating the bench copy
  function automatic deq_response_t predict_deque_response(
    action_t act, logic signed [DATA_W-1:0] value);
    deq_response_t r;
    r = NO_RESP;
    case (act)
      ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
        if (held >= CAP) begin
          r.status = ST_OVERFLOW;
        end else if (act == ACT_PUSH_FRONT) begin
          front_slot = (front_slot + CAP - 1) % CAP;
          slot_copy[front_slot] = value;
          held++;
        end else begin
          slot_copy[(front_slot + held) % CAP] = value;
          held++;
        end
      end
      ACT_POP_FRONT, ACT_POP_REAR: begin
        if (held == 0) begin
          r.popped_value = EMPTY_MARK;
          r.status = ST_UNDERFLOW;
        end else if (act == ACT_POP_FRONT) begin
          r.popped_value = slot_copy[front_slot];
          front_slot = (front_slot + 1) % CAP;
          held--;
        end else begin
          r.popped_value = slot_copy[(front_slot + held - 1) % CAP];
          held--;
        end
      end
    endcase
    r.is_empty  = (held == 0);
    r.is_full   = (held >= CAP);
    r.occupancy = held[OCC_W-1:0];
    if (held == 0) begin
      r.front_value = EMPTY_MARK;
      r.rear_value  = EMPTY_MARK;
    end else begin
      r.front_value = slot_copy[front_slot];
      r.rear_value  = slot_copy[(front_slot + held - 1) % CAP];
    end
    return r;
  endfunction

  // drive one request transaction and record what it should return
  task automatic send_request(action_t act, logic signed [DATA_W-1:0] value,
                              bit typed, deq_response_t typed_resp);
    int            gap;
    deq_response_t predicted;
    gap = $urandom_range(req_gap_max);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid      <= 1'b1;
    req.action     <= act;
    req.push_value <= value;
    do @(posedge clk); while (!req.ready);
    predicted = predict_deque_response(act, value);
    awaited_responses.push_back(typed ? typed_resp : predicted);
  endtask

  // compare one response transaction with the oldest expectation
  task automatic check_response();
    deq_response_t want;
    if (awaited_responses.size() == 0) begin
      fault_count++;
      if (fault_count <= 10)
        $display("unexpected response: popped=%0d status=%0d occ=%0d",
                 rsp.popped_value, rsp.status, rsp.occupancy);
    end else begin
      want = awaited_responses.pop_front();
      if (rsp.popped_value !== want.popped_value || rsp.status !== want.status ||
          rsp.is_empty !== want.is_empty || rsp.is_full !== want.is_full ||
          rsp.occupancy !== want.occupancy || rsp.front_value !== want.front_value ||
          rsp.rear_value !== want.rear_value) begin
        fault_count++;
        if (fault_count <= 10) begin
          $display("exp: popped=%0d st=%0d empty=%0b full=%0b occ=%0d front=%0d rear=%0d",
                   want.popped_value, want.status, want.is_empty, want.is_full,
                   want.occupancy, want.front_value, want.rear_value);
          $display("got: popped=%0d st=%0d empty=%0b full=%0b occ=%0d front=%0d rear=%0d",
                   rsp.popped_value, rsp.status, rsp.is_empty, rsp.is_full,
                   rsp.occupancy, rsp.front_value, rsp.rear_value);
        end
      end
    end
  endtask

  // response side: random stall before each transaction
  always @(posedge clk) begin
    if (rst) begin
      stall_left = 0;
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        check_response();
        stall_left = $urandom_range(rsp_stall_max);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      rsp.ready <= (stall_left == 0);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // stimulus and end of run
  initial begin
    int                       push_pct;
    action_t                  act;
    logic signed [DATA_W-1:0] value;
    clk            = 1'b0;
    rst            = 1'b1;
    req.valid      = 1'b0;
    req.action     = ACT_PUSH_FRONT;
    req.push_value = '0;
    fault_count    = 0;
    front_slot     = 0;
    held           = 0;
    req_gap_max    = 12;
    rsp_stall_max  = 12;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (directed_rows[i])
      send_request(directed_rows[i].act, directed_rows[i].value,
                   directed_rows[i].typed, directed_rows[i].resp);

    // random bursts leaning toward pushes, toward pops or toward neither
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % BURST_LEN == 0) begin
        case ($urandom_range(2))
          0: push_pct = 20;
          1: push_pct = 50;
          default: push_pct = 80;
        endcase
        req_gap_max   = ($urandom_range(2) == 0) ? 0 : 12;
        rsp_stall_max = ($urandom_range(2) == 0) ? 0 : 12;
      end
      if ($urandom_range(99) < push_pct)
        act = $urandom_range(1) ? ACT_PUSH_REAR : ACT_PUSH_FRONT;
      else
        act = $urandom_range(1) ? ACT_POP_REAR : ACT_POP_FRONT;
      case ($urandom_range(11))
        0: value = MAX_VAL;
        1: value = MIN_VAL;
        2: value = -32'sd1;
        3: value = 32'sd0;
        default: value = $urandom;
      endcase
      send_request(act, value, 1'b0, NO_RESP);
    end
    req.valid <= 1'b0;

    // drain outstanding responses
    while (awaited_responses.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0 && awaited_responses.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
